### hdl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants for the separable 5-tap Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RADIUS     = 2;
    localparam int DIM_MIN    = 5;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int AREA_W     = 21;

    // Sample and weight formats
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int LANES      = 4;
    localparam int LANE_W     = 2;

    // Register port
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    typedef logic signed [SAMPLE_W-1:0]      sample_t;
    typedef logic [LANES-1:0][SAMPLE_W-1:0]  row_word_t;
    typedef logic [COL_W-1:0]                col_t;
    typedef logic [LANE_W-1:0]               lane_t;
    typedef logic [DIM_W-1:0]                dim_t;
    typedef logic [AREA_W-1:0]               area_t;
    typedef logic [WEIGHT_W-1:0]             weight_t;

    typedef struct packed {
        weight_t w_center;
        weight_t w_near;
        weight_t w_far;
    } weights_t;

    // Settled configuration handed to the datapath
    typedef struct packed {
        dim_t     width;
        dim_t     height;
        area_t    area;
        weights_t weights;
        logic     hold;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WEIGHT_CENTER = 3'd2,
        REG_WEIGHT_NEAR   = 3'd3,
        REG_WEIGHT_FAR    = 3'd4
    } reg_index_t;

    localparam dim_t    RST_FRAME_WIDTH   = 11'd640;
    localparam dim_t    RST_FRAME_HEIGHT  = 11'd480;
    localparam weight_t RST_WEIGHT_CENTER = 16'd14588;
    localparam weight_t RST_WEIGHT_NEAR   = 16'd13800;
    localparam weight_t RST_WEIGHT_FAR    = 16'd11680;

endpackage

`default_nettype wire

### hdl/sgb_cfg.sv
// ----------------------------------------------------------------------------
// sgb_cfg
// Register bank on the APB-style port, with clamped frame size and area.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_cfg
    import sgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    dim_t       frame_width_reg;
    dim_t       frame_height_reg;
    weights_t   weights_reg;
    dim_t       width_clamp_reg;
    dim_t       height_clamp_reg;
    area_t      area_reg;
    logic       hold_reg;

    dim_t       width_clamp_next;
    dim_t       height_clamp_next;
    logic [2*DIM_W-1:0] area_full;
    logic       wr_transfer;
    reg_index_t reg_index;

    assign pready      = 1'b1;
    assign wr_transfer = psel && penable && pwrite;
    assign reg_index   = reg_index_t'(paddr[PADDR_W-1:2]);

    // Hold the registers, update on a completed write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= RST_FRAME_WIDTH;
            frame_height_reg     <= RST_FRAME_HEIGHT;
            weights_reg.w_center <= RST_WEIGHT_CENTER;
            weights_reg.w_near   <= RST_WEIGHT_NEAR;
            weights_reg.w_far    <= RST_WEIGHT_FAR;
        end
        else if (wr_transfer)
        begin
            unique case (reg_index)
                REG_FRAME_WIDTH:   frame_width_reg      <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg     <= pwdata[DIM_W-1:0];
                REG_WEIGHT_CENTER: weights_reg.w_center <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_NEAR:   weights_reg.w_near   <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_FAR:    weights_reg.w_far    <= pwdata[WEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_FRAME_WIDTH:   prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:  prdata = PDATA_W'(frame_height_reg);
            REG_WEIGHT_CENTER: prdata = PDATA_W'(weights_reg.w_center);
            REG_WEIGHT_NEAR:   prdata = PDATA_W'(weights_reg.w_near);
            REG_WEIGHT_FAR:    prdata = PDATA_W'(weights_reg.w_far);
            default:           prdata = '0;
        endcase
    end

    // Clamp the frame size to the supported range
    always_comb
    begin
        if (frame_width_reg < DIM_W'(DIM_MIN))
            width_clamp_next = DIM_W'(DIM_MIN);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            width_clamp_next = DIM_W'(MAX_WIDTH);
        else
            width_clamp_next = frame_width_reg;

        if (frame_height_reg < DIM_W'(DIM_MIN))
            height_clamp_next = DIM_W'(DIM_MIN);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            height_clamp_next = DIM_W'(MAX_HEIGHT);
        else
            height_clamp_next = frame_height_reg;
    end

    assign area_full = width_clamp_next * height_clamp_next;

    // Register the derived values; hold off items for one cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_clamp_reg  <= RST_FRAME_WIDTH;
            height_clamp_reg <= RST_FRAME_HEIGHT;
            area_reg         <= AREA_W'(RST_FRAME_WIDTH * RST_FRAME_HEIGHT);
            hold_reg         <= 1'b0;
        end
        else
        begin
            width_clamp_reg  <= width_clamp_next;
            height_clamp_reg <= height_clamp_next;
            area_reg         <= area_full[AREA_W-1:0];
            hold_reg         <= wr_transfer;
        end
    end

    assign cfg.width   = width_clamp_reg;
    assign cfg.height  = height_clamp_reg;
    assign cfg.area    = area_reg;
    assign cfg.weights = weights_reg;
    assign cfg.hold    = hold_reg;

endmodule

`default_nettype wire

### hdl/sgb_taps.sv
// ----------------------------------------------------------------------------
// sgb_taps
// Symmetric 5-tap filter: pre-add, multiply, then sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_taps
    import sgb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire weights_t weights,
    input  wire sample_t  m2,
    input  wire sample_t  m1,
    input  wire sample_t  c0,
    input  wire sample_t  p1,
    input  wire sample_t  p2,
    output sample_t       y
);

    localparam int PAIR_W = SAMPLE_W + 1;
    localparam int PROD_W = 2 * PAIR_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - WEIGHT_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (WEIGHT_W - 1);
    localparam logic signed [Q_W-1:0]   SAT_HI = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO = -Q_W'(1 << (SAMPLE_W - 1));

    logic signed [PAIR_W-1:0] center_reg;
    logic signed [PAIR_W-1:0] pair_near_reg;
    logic signed [PAIR_W-1:0] pair_far_reg;
    logic signed [PROD_W-1:0] prod_center_reg;
    logic signed [PROD_W-1:0] prod_near_reg;
    logic signed [PROD_W-1:0] prod_far_reg;

    logic signed [PAIR_W-1:0] wc_s;
    logic signed [PAIR_W-1:0] wn_s;
    logic signed [PAIR_W-1:0] wf_s;
    logic signed [ACC_W-1:0]  acc;
    logic signed [Q_W-1:0]    q;

    assign wc_s = signed'({1'b0, weights.w_center});
    assign wn_s = signed'({1'b0, weights.w_near});
    assign wf_s = signed'({1'b0, weights.w_far});

    // Fold the symmetric taps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_reg    <= PAIR_W'(c0);
            pair_near_reg <= PAIR_W'(m1) + PAIR_W'(p1);
            pair_far_reg  <= PAIR_W'(m2) + PAIR_W'(p2);
        end
    end

    // Weight the three folded terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_center_reg <= wc_s * center_reg;
            prod_near_reg   <= wn_s * pair_near_reg;
            prod_far_reg    <= wf_s * pair_far_reg;
        end
    end

    // Sum, round half up, drop the fraction and saturate
    assign acc = ACC_W'(prod_center_reg) + ACC_W'(prod_near_reg)
               + ACC_W'(prod_far_reg) + ROUND_HALF;
    assign q   = acc[ACC_W-1:WEIGHT_W];

    always_comb
    begin
        if (q > SAT_HI)
            y = SAT_HI[SAMPLE_W-1:0];
        else if (q < SAT_LO)
            y = SAT_LO[SAMPLE_W-1:0];
        else
            y = q[SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

### hdl/sgb_line_store.sv
// ----------------------------------------------------------------------------
// sgb_line_store
// Four-row line store, one word of four samples per column, with write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_line_store
    import sgb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rd_en,
    input  wire col_t    rd_addr,
    output row_word_t    rd_word,
    input  wire logic    wb_en,
    input  wire col_t    wb_addr,
    input  wire lane_t   wb_lane,
    input  wire sample_t wb_sample
);

    row_word_t mem [MAX_WIDTH];
    row_word_t rd_word_reg;
    row_word_t wb_word;

    // Replace the lane of the oldest row in the word just read. Consecutive
    // items always sit in different columns, so a read never meets a pending
    // write to the same entry.
    always_comb
    begin
        wb_word          = rd_word_reg;
        wb_word[wb_lane] = wb_sample;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_word_reg <= mem[rd_addr];
        if (wb_en)
            mem[wb_addr] <= wb_word;
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

### hdl/separable_gaussian_blur_5tap.sv
// Pipeline: stages s1 to s6 carry a result to the output register after the transfer of
// the item that completes it; the stream lags the input by two rows and two columns.
// Throughput: one item per cycle if the output does not stall, set by the line store's
// single read-modify-write port; input ready drops for one cycle after each register write.
// Reset: position counters, tap window and output valid clear; registers take their reset
// values; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
// separable_gaussian_blur_5tap
// Streaming 5-tap separable Gaussian blur: vertical pass from a four-row line
// store, then horizontal pass over a five-sample window, Q8.8 in and out.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_gaussian_blur_5tap
    import sgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // Input items
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire sample_t            sample_in,
    input  wire logic               drain,
    // Results
    output logic                    result_valid,
    input  wire logic               result_ready,
    output sample_t                 sample_out,
    output logic                    end_of_frame
);

    typedef enum logic [1:0] {
        VERT_ZERO = 2'd0,
        VERT_TAPS = 2'd1,
        VERT_PASS = 2'd2
    } vert_mode_t;

    typedef struct packed {
        vert_mode_t vmode;
        lane_t      row_lo;
        col_t       col;
        logic       we;
        logic       emit;
        logic       border_h;
        logic       eof;
    } item_ctl_t;

    localparam int   CQ_W = DIM_W + 1;
    localparam dim_t RAD  = DIM_W'(RADIUS);

    cfg_t cfg;

    // Frame position
    col_t      in_column_reg, in_column_next;
    dim_t      in_row_reg,    in_row_next;
    area_t     out_count_reg, out_count_next;

    // Pipeline
    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic      s4_valid_reg, s5_valid_reg, s6_valid_reg;
    item_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, s6_ctl_reg;
    sample_t   s1_x_reg;
    sample_t   s2_pass_reg, s3_pass_reg;
    sample_t   s5_center_reg, s6_center_reg;
    sample_t   window_reg [5];

    // Output register
    logic      result_valid_reg;
    sample_t   sample_out_reg;
    logic      end_of_frame_reg;

    logic      adv;
    logic      take;
    logic      flush;
    logic      ignore;
    logic      proc;
    logic      emit;
    logic      eof;
    logic      row_end;
    area_t     out_count_inc;
    logic [CQ_W-1:0] col_ext;
    logic [CQ_W-1:0] width_ext;
    logic [CQ_W-1:0] cq;
    item_ctl_t s0_ctl;

    row_word_t rd_word;
    lane_t     lane_m1, lane_c0, lane_p1;
    sample_t   v_taps;
    sample_t   v_s3;
    sample_t   h_taps;
    sample_t   y_s6;

    sgb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stall the whole pipeline only when a result meets a full output register
    assign adv        = !(s6_valid_reg && s6_ctl_reg.emit && result_valid_reg && !result_ready);
    assign item_ready = adv && !cfg.hold;
    assign take       = item_valid && item_ready;

    // Classify the incoming item
    assign flush  = in_row_reg >= cfg.height;
    assign ignore = !flush && drain;
    assign proc   = take && !ignore;
    assign emit   = (in_row_reg > RAD) || ((in_row_reg == RAD) && (DIM_W'(in_column_reg) >= RAD));
    assign out_count_inc = out_count_reg + AREA_W'(1);
    assign eof    = emit && (out_count_inc >= cfg.area);
    assign row_end = (DIM_W'(in_column_reg) + DIM_W'(1)) >= cfg.width;

    // Output column and horizontal border
    assign col_ext   = CQ_W'(in_column_reg);
    assign width_ext = CQ_W'(cfg.width);
    assign cq = (col_ext >= CQ_W'(RADIUS)) ? col_ext - CQ_W'(RADIUS)
                                           : col_ext + width_ext - CQ_W'(RADIUS);

    always_comb
    begin
        s0_ctl.row_lo   = in_row_reg[LANE_W-1:0];
        s0_ctl.col      = in_column_reg;
        s0_ctl.we       = !flush;
        s0_ctl.emit     = emit;
        s0_ctl.border_h = (cq < CQ_W'(RADIUS)) || ((cq + CQ_W'(RADIUS)) >= width_ext);
        s0_ctl.eof      = eof;
        priority if (in_row_reg < RAD)
            s0_ctl.vmode = VERT_ZERO;
        else if ((in_row_reg >= DIM_W'(2 * RADIUS)) && !flush)
            s0_ctl.vmode = VERT_TAPS;
        else
            s0_ctl.vmode = VERT_PASS;
    end

    // Advance the frame position
    always_comb
    begin
        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        if (proc)
        begin
            if (eof)
            begin
                in_column_next = '0;
                in_row_next    = '0;
                out_count_next = '0;
            end
            else
            begin
                if (emit)
                    out_count_next = out_count_inc;
                if (row_end)
                begin
                    in_column_next = '0;
                    in_row_next    = in_row_reg + DIM_W'(1);
                end
                else
                begin
                    in_column_next = in_column_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
            out_count_reg <= out_count_next;
        end
    end

    // Line store: read at transfer, write back the new sample from stage s1 as it advances
    sgb_line_store u_line_store (
        .clk       (clk),
        .rd_en     (proc),
        .rd_addr   (in_column_reg),
        .rd_word   (rd_word),
        .wb_en     (adv && s1_valid_reg && s1_ctl_reg.we),
        .wb_addr   (s1_ctl_reg.col),
        .wb_lane   (s1_ctl_reg.row_lo),
        .wb_sample (s1_x_reg)
    );

    // Lanes hold rows r-4 .. r-1 starting at the lane of the current row
    assign lane_m1 = s1_ctl_reg.row_lo + lane_t'(1);
    assign lane_c0 = s1_ctl_reg.row_lo + lane_t'(2);
    assign lane_p1 = s1_ctl_reg.row_lo + lane_t'(3);

    sgb_taps u_vert_taps (
        .clk     (clk),
        .en      (adv),
        .weights (cfg.weights),
        .m2      (sample_t'(rd_word[s1_ctl_reg.row_lo])),
        .m1      (sample_t'(rd_word[lane_m1])),
        .c0      (sample_t'(rd_word[lane_c0])),
        .p1      (sample_t'(rd_word[lane_p1])),
        .p2      (s1_x_reg),
        .y       (v_taps)
    );

    // Vertical result: zero above the frame, the stored row near the edges
    always_comb
    begin
        unique case (s3_ctl_reg.vmode)
            VERT_ZERO: v_s3 = '0;
            VERT_TAPS: v_s3 = v_taps;
            VERT_PASS: v_s3 = s3_pass_reg;
            default:   v_s3 = '0;
        endcase
    end

    sgb_taps u_horz_taps (
        .clk     (clk),
        .en      (adv),
        .weights (cfg.weights),
        .m2      (window_reg[0]),
        .m1      (window_reg[1]),
        .c0      (window_reg[2]),
        .p1      (window_reg[3]),
        .p2      (window_reg[4]),
        .y       (h_taps)
    );

    assign y_s6 = s6_ctl_reg.border_h ? s6_center_reg : h_taps;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= proc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg    <= s0_ctl;
            s1_x_reg      <= sample_in;
            s2_ctl_reg    <= s1_ctl_reg;
            s2_pass_reg   <= sample_t'(rd_word[lane_c0]);
            s3_ctl_reg    <= s2_ctl_reg;
            s3_pass_reg   <= s2_pass_reg;
            s4_ctl_reg    <= s3_ctl_reg;
            s5_ctl_reg    <= s4_ctl_reg;
            s5_center_reg <= window_reg[2];
            s6_ctl_reg    <= s5_ctl_reg;
            s6_center_reg <= s5_center_reg;
        end
    end

    // Shift the vertical result into the tap window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                window_reg[i] <= '0;
        end
        else if (adv && s3_valid_reg)
        begin
            for (int i = 0; i < 4; i++)
                window_reg[i] <= window_reg[i+1];
            window_reg[4] <= v_s3;
        end
    end

    // Output register: load a new result, drop a taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv && s6_valid_reg && s6_ctl_reg.emit)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s6_valid_reg && s6_ctl_reg.emit)
        begin
            sample_out_reg   <= y_s6;
            end_of_frame_reg <= s6_ctl_reg.eof;
        end
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule

`default_nettype wire
